@@ hdl/lfrc_pkg.sv @@
// ----------------------------------------------------------------------------
// lfrc_pkg
// Shared types and constants for the line follow recovery controller.
// ----------------------------------------------------------------------------
package lfrc_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned STEER_W = 13;
  localparam int unsigned SPEED_W = 8;
  localparam int unsigned TICK_W  = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_ALIGNED   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SCAN      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_REV_SCAN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_ONTO      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_ALIGN     = 3'd4;
  localparam logic [MODE_W-1:0] MODE_REV_ALIGN = 3'd5;
  localparam logic [MODE_W-1:0] MODE_LOST      = 3'd6;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SPEED = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FOLLOW_SWING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCAN_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_SPEED   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LOST_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_QUARTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_HALF    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MOVE_ONTO    = 3'd7;

  // register reset values
  localparam logic [SPEED_W-1:0] RST_FOLLOW_SPEED = 8'd150;
  localparam logic [SPEED_W-1:0] RST_FOLLOW_SWING = 8'd100;
  localparam logic [SPEED_W-1:0] RST_SCAN_SPEED   = 8'd150;
  localparam logic [SPEED_W-1:0] RST_MOVE_SPEED   = 8'd200;
  localparam logic [TICK_W-1:0]  RST_LOST_LIMIT   = 16'd150;
  localparam logic [TICK_W-1:0]  RST_TURN_QUARTER = 16'd1000;
  localparam logic [TICK_W-1:0]  RST_TURN_HALF    = 16'd2000;
  localparam logic [TICK_W-1:0]  RST_MOVE_ONTO    = 16'd500;

  typedef struct packed {
    logic [SPEED_W-1:0] follow_speed;
    logic [SPEED_W-1:0] follow_swing;
    logic [SPEED_W-1:0] scan_speed;
    logic [SPEED_W-1:0] move_speed;
    logic [TICK_W-1:0]  lost_limit;
    logic [TICK_W-1:0]  turn_quarter_ms;
    logic [TICK_W-1:0]  turn_half_ms;
    logic [TICK_W-1:0]  move_onto_ms;
  } lfrc_cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]         now_ms;
    logic signed [STEER_W-1:0] steer;
    logic                      line_seen;
    logic                      force_find;
  } lfrc_item_t;

  typedef struct packed {
    logic [SPEED_W-1:0] left_speed;
    logic [SPEED_W-1:0] right_speed;
    logic               left_reverse;
    logic               right_reverse;
    logic [MODE_W-1:0]  mode;
    logic               line_ok;
  } lfrc_res_t;

endpackage

@@ hdl/lfrc_in_if.sv @@
// ----------------------------------------------------------------------------
// lfrc_in_if
// Update request channel: valid/ready with timestamp, steering and flags.
// ----------------------------------------------------------------------------
interface lfrc_in_if;
  import lfrc_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [TIME_W-1:0]         now_ms;
  logic signed [STEER_W-1:0] steer;
  logic                      line_seen;
  logic                      force_find;

  modport source (output valid, now_ms, steer, line_seen, force_find, input ready);
  modport sink   (input valid, now_ms, steer, line_seen, force_find, output ready);
endinterface

@@ hdl/lfrc_out_if.sv @@
// ----------------------------------------------------------------------------
// lfrc_out_if
// Motor command channel: valid/ready with speeds, directions and status.
// ----------------------------------------------------------------------------
interface lfrc_out_if;
  import lfrc_pkg::*;

  logic               valid;
  logic               ready;
  logic [SPEED_W-1:0] left_speed;
  logic [SPEED_W-1:0] right_speed;
  logic               left_reverse;
  logic               right_reverse;
  logic [MODE_W-1:0]  mode;
  logic               line_ok;

  modport source (output valid, left_speed, right_speed, left_reverse, right_reverse,
                  mode, line_ok, input ready);
  modport sink   (input valid, left_speed, right_speed, left_reverse, right_reverse,
                  mode, line_ok, output ready);
endinterface

@@ hdl/lfrc_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// lfrc_cfg_regs
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module lfrc_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lfrc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lfrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output lfrc_pkg::lfrc_cfg_t           cfg
);
  import lfrc_pkg::*;

  lfrc_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.follow_speed    <= RST_FOLLOW_SPEED;
      cfg_r.follow_swing    <= RST_FOLLOW_SWING;
      cfg_r.scan_speed      <= RST_SCAN_SPEED;
      cfg_r.move_speed      <= RST_MOVE_SPEED;
      cfg_r.lost_limit      <= RST_LOST_LIMIT;
      cfg_r.turn_quarter_ms <= RST_TURN_QUARTER;
      cfg_r.turn_half_ms    <= RST_TURN_HALF;
      cfg_r.move_onto_ms    <= RST_MOVE_ONTO;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FOLLOW_SPEED: cfg_r.follow_speed    <= cfg_wdata[SPEED_W-1:0];
        CFG_FOLLOW_SWING: cfg_r.follow_swing    <= cfg_wdata[SPEED_W-1:0];
        CFG_SCAN_SPEED:   cfg_r.scan_speed      <= cfg_wdata[SPEED_W-1:0];
        CFG_MOVE_SPEED:   cfg_r.move_speed      <= cfg_wdata[SPEED_W-1:0];
        CFG_LOST_LIMIT:   cfg_r.lost_limit      <= cfg_wdata[TICK_W-1:0];
        CFG_TURN_QUARTER: cfg_r.turn_quarter_ms <= cfg_wdata[TICK_W-1:0];
        CFG_TURN_HALF:    cfg_r.turn_half_ms    <= cfg_wdata[TICK_W-1:0];
        CFG_MOVE_ONTO:    cfg_r.move_onto_ms    <= cfg_wdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;
endmodule

@@ hdl/lfrc_core.sv @@
// ----------------------------------------------------------------------------
// lfrc_core
// Recovery state machine and motor command update, one update per enable.
// ----------------------------------------------------------------------------
module lfrc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step_en,
  input  lfrc_pkg::lfrc_item_t item,
  input  lfrc_pkg::lfrc_cfg_t  cfg,
  output lfrc_pkg::lfrc_res_t  res
);
  import lfrc_pkg::*;

  typedef enum logic [MODE_W-1:0] {
    MD_ALIGNED   = MODE_ALIGNED,
    MD_SCAN      = MODE_SCAN,
    MD_REV_SCAN  = MODE_REV_SCAN,
    MD_ONTO      = MODE_ONTO,
    MD_ALIGN     = MODE_ALIGN,
    MD_REV_ALIGN = MODE_REV_ALIGN,
    MD_LOST      = MODE_LOST
  } mode_t;

  mode_t              mode_r, mode_nxt;
  logic [TICK_W-1:0]  lost_r, lost_nxt;
  logic               scan_right_r, scan_right_nxt;
  logic               busy_r, busy_nxt;
  logic [TIME_W-1:0]  stop_r, stop_nxt;
  logic [SPEED_W-1:0] left_r, left_nxt, right_r, right_nxt;
  logic               left_back_r, left_back_nxt, right_back_r, right_back_nxt;

  logic signed [STEER_W:0] steer_l, steer_rn;
  logic [SPEED_W-1:0]      follow_l, follow_rt;
  logic [TICK_W-1:0]       ticks;
  logic                    timed, done;

  // (s*swing + speed*1024) >> 10, floored at 0 and saturated at 255
  function automatic logic [SPEED_W-1:0] follow_level(input logic signed [STEER_W:0] s,
                                                      input logic [SPEED_W-1:0] swing,
                                                      input logic [SPEED_W-1:0] speed);
    logic signed [23:0] prod;
    logic signed [23:0] v;
    prod = $signed({{(24-STEER_W-1){s[STEER_W]}}, s}) * $signed({16'd0, swing});
    v    = prod + $signed({6'd0, speed, 10'd0});
    if (v[23])
      return '0;
    else if (v[22:18] != '0)
      return '1;
    else
      return v[17:10];
  endfunction

  assign steer_l  = {item.steer[STEER_W-1], item.steer};
  assign steer_rn = -steer_l;
  assign follow_l  = follow_level(steer_l, cfg.follow_swing, cfg.follow_speed);
  assign follow_rt = follow_level(steer_rn, cfg.follow_swing, cfg.follow_speed);

  always_comb begin
    mode_nxt       = mode_r;
    scan_right_nxt = scan_right_r;
    busy_nxt       = busy_r;
    stop_nxt       = stop_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    left_back_nxt  = left_back_r;
    right_back_nxt = right_back_r;
    ticks          = cfg.move_onto_ms;

    if (item.line_seen)
      lost_nxt = '0;
    else if (lost_r != '1)
      lost_nxt = lost_r + 1'b1;
    else
      lost_nxt = lost_r;

    if (item.force_find || (lost_nxt > cfg.lost_limit && mode_r == MD_ALIGNED) ||
        (item.line_seen && mode_r == MD_LOST)) begin
      mode_nxt       = MD_SCAN;
      busy_nxt       = 1'b0;
      scan_right_nxt = !item.steer[STEER_W-1];
    end

    timed = mode_nxt inside {MD_SCAN, MD_REV_SCAN, MD_ONTO, MD_ALIGN, MD_REV_ALIGN};
    if (mode_nxt inside {MD_SCAN, MD_ALIGN})
      ticks = cfg.turn_quarter_ms;
    else if (mode_nxt inside {MD_REV_SCAN, MD_REV_ALIGN})
      ticks = cfg.turn_half_ms;

    // shared timed turn / move step
    if (timed) begin
      if (!busy_nxt) begin
        busy_nxt  = 1'b1;
        stop_nxt  = item.now_ms + TIME_W'(ticks);
        if (mode_nxt == MD_ONTO) begin
          left_nxt       = cfg.move_speed;
          right_nxt      = cfg.move_speed;
          left_back_nxt  = 1'b0;
          right_back_nxt = 1'b0;
        end else begin
          left_nxt       = cfg.scan_speed;
          right_nxt      = cfg.scan_speed;
          left_back_nxt  = !scan_right_nxt;
          right_back_nxt = scan_right_nxt;
        end
      end
      if (item.now_ms >= stop_nxt) begin
        busy_nxt       = 1'b0;
        left_nxt       = '0;
        right_nxt      = '0;
        left_back_nxt  = 1'b0;
        right_back_nxt = 1'b0;
      end
    end
    done = !busy_nxt;

    case (mode_nxt)
      MD_ALIGNED: begin
        left_nxt       = follow_l;
        right_nxt      = follow_rt;
        left_back_nxt  = 1'b0;
        right_back_nxt = 1'b0;
      end
      MD_SCAN, MD_REV_SCAN: begin
        if (done) begin
          if (mode_nxt == MD_SCAN) begin
            mode_nxt       = MD_REV_SCAN;
            scan_right_nxt = !scan_right_nxt;
          end else begin
            mode_nxt = MD_LOST;
          end
        end
        if (item.line_seen) begin
          mode_nxt = MD_ONTO;
          busy_nxt = 1'b0;
        end
      end
      MD_ONTO: begin
        if (done) begin
          mode_nxt       = MD_ALIGN;
          scan_right_nxt = !scan_right_nxt;
        end
      end
      MD_ALIGN, MD_REV_ALIGN: begin
        if (done) begin
          if (mode_nxt == MD_ALIGN) begin
            mode_nxt       = MD_REV_ALIGN;
            scan_right_nxt = !scan_right_nxt;
          end else begin
            mode_nxt = MD_LOST;
          end
        end
        if (item.line_seen) begin
          mode_nxt       = MD_ALIGNED;
          left_nxt       = '0;
          right_nxt      = '0;
          left_back_nxt  = 1'b0;
          right_back_nxt = 1'b0;
          lost_nxt       = '0;
          busy_nxt       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MD_ALIGNED;
      lost_r       <= '0;
      scan_right_r <= 1'b0;
      busy_r       <= 1'b0;
      stop_r       <= '0;
      left_r       <= '0;
      right_r      <= '0;
      left_back_r  <= 1'b0;
      right_back_r <= 1'b0;
    end else if (step_en) begin
      mode_r       <= mode_nxt;
      lost_r       <= lost_nxt;
      scan_right_r <= scan_right_nxt;
      busy_r       <= busy_nxt;
      stop_r       <= stop_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
      left_back_r  <= left_back_nxt;
      right_back_r <= right_back_nxt;
    end
  end

  assign res.left_speed    = left_nxt;
  assign res.right_speed   = right_nxt;
  assign res.left_reverse  = left_back_nxt;
  assign res.right_reverse = right_back_nxt;
  assign res.mode          = mode_nxt;
  assign res.line_ok       = (mode_nxt != MD_LOST);
endmodule

@@ hdl/line_follow_recovery_controller_top.sv @@
// ----------------------------------------------------------------------------
// line_follow_recovery_controller_top
// Line follower with lost-line recovery sequence, one command per update.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : update requests (now_ms, steer, line_seen, force_find), valid/ready.
//   out_ch : one motor command per request (speeds, directions, mode, line_ok).
//   cfg_*  : register writes, index 0..7; write only while no request is in
//            flight.
// Path: a request accepted on in_ch goes into the input register, then the
//   state update writes its result into the result register that drives out_ch.
// Throughput: one request per cycle while out_ch.ready is high; the state update
//   is a single pass of logic from the input register to the result register.
// Reset (rst_n low, synchronous): registers return to defaults, the mode to
//   aligned, motors stopped, both pipeline registers empty.
// Stall: while out_ch.ready is low the result holds; the input register
//   still takes one request and in_ch.ready then drops until the result is
//   taken.
// ----------------------------------------------------------------------------
module line_follow_recovery_controller_top (
  input  logic                            clk,
  input  logic                            rst_n,
  lfrc_in_if.sink                         in_ch,
  lfrc_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lfrc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lfrc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfrc_pkg::*;

  lfrc_cfg_t  cfg;
  lfrc_item_t item_r;
  lfrc_res_t  res, res_r;
  logic       in_v_r, out_v_r;
  logic       adv;

  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  lfrc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lfrc_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (adv),
    .item    (item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready)
        in_v_r <= in_ch.valid;
      if (adv)
        out_v_r <= 1'b1;
      else if (out_ch.ready)
        out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      item_r.now_ms     <= in_ch.now_ms;
      item_r.steer      <= in_ch.steer;
      item_r.line_seen  <= in_ch.line_seen;
      item_r.force_find <= in_ch.force_find;
    end
    if (adv)
      res_r <= res;
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.left_speed    = res_r.left_speed;
  assign out_ch.right_speed   = res_r.right_speed;
  assign out_ch.left_reverse  = res_r.left_reverse;
  assign out_ch.right_reverse = res_r.right_reverse;
  assign out_ch.mode          = res_r.mode;
  assign out_ch.line_ok       = res_r.line_ok;
endmodule

@@ hdl/lfrc_checker.sv @@
// ----------------------------------------------------------------------------
// lfrc_checker
// Port-level checks for the line follow recovery controller.
// ----------------------------------------------------------------------------
module lfrc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [lfrc_pkg::SPEED_W-1:0]  left_speed,
  input logic [lfrc_pkg::SPEED_W-1:0]  right_speed,
  input logic                          left_reverse,
  input logic                          right_reverse,
  input logic [lfrc_pkg::MODE_W-1:0]   mode,
  input logic                          line_ok
);
  import lfrc_pkg::*;

  // status flag must track the lost mode
  a_line_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (line_ok == (mode != MODE_LOST)))
    else $error("line_ok does not match mode");

  // lost mode always stops both motors
  a_lost_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode == MODE_LOST) |->
      (left_speed == '0 && right_speed == '0 && !left_reverse && !right_reverse))
    else $error("motors not stopped in lost mode");

  // following never drives backward
  a_follow_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && mode == MODE_ALIGNED) |-> (!left_reverse && !right_reverse))
    else $error("reverse command while following");

  // no result can appear the cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(mode) && $stable(left_speed)
      && $stable(right_speed)))
    else $error("stalled result changed");
endmodule

bind line_follow_recovery_controller_top lfrc_checker u_lfrc_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .left_speed    (out_ch.left_speed),
  .right_speed   (out_ch.right_speed),
  .left_reverse  (out_ch.left_reverse),
  .right_reverse (out_ch.right_reverse),
  .mode          (out_ch.mode),
  .line_ok       (out_ch.line_ok)
);
